// ===== rtl/core/spab_pkg.sv =====
// Package for the span pixel alpha blend unit: transfer payload types, stage
// structs, operation codes and register map. It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package spab_pkg;

	localparam int unsigned APB_ADDR_W = 5;
	localparam int unsigned APB_DATA_W = 32;

	localparam logic [2:0] REG_PIXEL_FORMAT = 3'd0;
	localparam logic [2:0] REG_FILL_ALPHA   = 3'd1;
	localparam logic [2:0] REG_FILL_RED     = 3'd2;
	localparam logic [2:0] REG_FILL_GREEN   = 3'd3;
	localparam logic [2:0] REG_FILL_BLUE    = 3'd4;

	localparam logic [1:0] FMT_BGRA = 2'd0;
	localparam logic [1:0] FMT_BGRX = 2'd1;
	localparam logic [1:0] FMT_RGBX = 2'd2;
	localparam logic [1:0] FMT_RGBA = 2'd3;

	localparam logic [1:0] REQ_FILL        = 2'd0;
	localparam logic [1:0] REQ_FILL_SCALED = 2'd1;
	localparam logic [1:0] REQ_STENCIL     = 2'd2;
	localparam logic [1:0] REQ_ERASE       = 2'd3;

	localparam logic [7:0] BYTE_FULL = 8'hFF;

	typedef enum logic [2:0] {
		OP_KEEP,
		OP_ZERO,
		OP_STORE,
		OP_LERP,
		OP_PREMUL
	} spab_op_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] coverage;
		logic [7:0] src_alpha;
		logic [7:0] src_red;
		logic [7:0] src_green;
		logic [7:0] src_blue;
		logic [7:0] dst_byte0;
		logic [7:0] dst_byte1;
		logic [7:0] dst_byte2;
		logic [7:0] dst_byte3;
	} spab_in_t;

	typedef struct packed {
		logic [7:0] out_byte0;
		logic [7:0] out_byte1;
		logic [7:0] out_byte2;
		logic [7:0] out_byte3;
		logic       write_enable;
	} spab_out_t;

	typedef struct packed {
		logic [1:0] pixel_format;
		logic [7:0] fill_alpha;
		logic [7:0] fill_red;
		logic [7:0] fill_green;
		logic [7:0] fill_blue;
	} spab_cfg_t;

	// Decoded pixel after alpha setup.
	typedef struct packed {
		spab_op_t        op;
		logic [7:0]      alpha;
		logic [2:0][7:0] col;
		logic [3:0][7:0] dst;
		logic [7:0]      b3;
		logic            b3_fixed;
	} spab_s2_t;

	// Pixel with all channel products formed.
	typedef struct packed {
		spab_op_t        op;
		logic [2:0][7:0] col;
		logic [3:0][7:0] dst;
		logic [7:0]      b3;
		logic            b3_fixed;
		logic [2:0][7:0] lerp_q;
		logic [2:0][7:0] pm_src;
		logic [2:0][7:0] pm_dst;
		logic [7:0]      aa;
		logic [7:0]      ad3;
	} spab_s3_t;

endpackage

`default_nettype wire

// ===== rtl/core/span_pixel_alpha_blend.sv =====
// Top level of the span pixel alpha blend unit: register file and the four
// stage blend pipeline. Depends on spab_pkg, spab_regs, spab_setup, spab_blend.
//
// Composites one pixel per transfer: the operation, coverage, stencil color
// and the four destination bytes go in, the four new bytes and a write-enable
// come out. The pipeline accepts one pixel every cycle when not stalled and
// passes each through four registered stages (input register, alpha setup
// with its 9x8 multiply, channel multiplies, final combine into the output
// register). Each stage holds its own valid bit, so a stall on the output
// side only backs up as far as the first empty stage. Write the configuration
// registers only while no pixel is in flight.
`timescale 1ns / 1ps
`default_nettype none

module span_pixel_alpha_blend (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [spab_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [spab_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [spab_pkg::APB_DATA_W-1:0] prdata,
	output logic                                 pready,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire spab_pkg::spab_in_t              in_data,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output spab_pkg::spab_out_t                  out_data
);
	import spab_pkg::*;

	spab_cfg_t cfg;
	logic      s2_valid;
	logic      s2_stall;
	spab_s2_t  s2_data;

	spab_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	spab_setup u_setup (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.s2_valid (s2_valid),
		.s2_stall (s2_stall),
		.s2_data  (s2_data)
	);

	spab_blend u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.s2_valid  (s2_valid),
		.s2_stall  (s2_stall),
		.s2_data   (s2_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

// ===== rtl/core/spab_regs.sv =====
// Configuration register file of the span pixel alpha blend unit on an
// APB-style port. Depends on spab_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spab_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [spab_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [spab_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [spab_pkg::APB_DATA_W-1:0] prdata,
	output logic                                pready,
	output spab_pkg::spab_cfg_t                 cfg
);
	import spab_pkg::*;

	spab_cfg_t   cfg_q;
	logic [2:0]  reg_idx;
	logic        wr_en;

	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_format <= FMT_BGRA;
			cfg_q.fill_alpha   <= BYTE_FULL;
			cfg_q.fill_red     <= 8'd0;
			cfg_q.fill_green   <= 8'd0;
			cfg_q.fill_blue    <= 8'd0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_PIXEL_FORMAT: cfg_q.pixel_format <= pwdata[1:0];
				REG_FILL_ALPHA:   cfg_q.fill_alpha   <= pwdata[7:0];
				REG_FILL_RED:     cfg_q.fill_red     <= pwdata[7:0];
				REG_FILL_GREEN:   cfg_q.fill_green   <= pwdata[7:0];
				REG_FILL_BLUE:    cfg_q.fill_blue    <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_idx)
			REG_PIXEL_FORMAT: prdata = {{(APB_DATA_W-2){1'b0}}, cfg_q.pixel_format};
			REG_FILL_ALPHA:   prdata = {{(APB_DATA_W-8){1'b0}}, cfg_q.fill_alpha};
			REG_FILL_RED:     prdata = {{(APB_DATA_W-8){1'b0}}, cfg_q.fill_red};
			REG_FILL_GREEN:   prdata = {{(APB_DATA_W-8){1'b0}}, cfg_q.fill_green};
			REG_FILL_BLUE:    prdata = {{(APB_DATA_W-8){1'b0}}, cfg_q.fill_blue};
			default:          prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/spab_setup.sv =====
// Front half of the blend pipeline: input register (s1) and the stage that
// forms the blend alpha and decodes the operation (s2). Depends on spab_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spab_setup (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire spab_pkg::spab_cfg_t cfg,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire spab_pkg::spab_in_t  in_data,
	output logic                     s2_valid,
	input  wire logic                s2_stall,
	output spab_pkg::spab_s2_t       s2_data
);
	import spab_pkg::*;

	logic       valid_s1;
	spab_in_t   pix_s1;
	logic       valid_s2;
	spab_s2_t   pix_s2;
	logic       rdy_s1;
	logic       rdy_s2;

	logic            has_alpha;
	logic [7:0]      mul_a;
	logic [8:0]      mul_ap1;
	logic [16:0]     mul_prod;
	logic [7:0]      scaled_a;
	logic [3:0][7:0] dst;
	spab_s2_t        nxt;

	function automatic logic [2:0][7:0] layout_order(logic [1:0] fmt, logic [7:0] r,
		logic [7:0] g, logic [7:0] b);
		logic [2:0][7:0] c;
		if (fmt == FMT_BGRA || fmt == FMT_BGRX) begin
			c[0] = b; c[1] = g; c[2] = r;
		end else begin
			c[0] = r; c[1] = g; c[2] = b;
		end
		return c;
	endfunction

	assign rdy_s2   = !valid_s2 || !s2_stall;
	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign in_stall = !rdy_s1;
	assign s2_valid = valid_s2;
	assign s2_data  = pix_s2;

	assign has_alpha = (cfg.pixel_format == FMT_BGRA) || (cfg.pixel_format == FMT_RGBA);
	assign dst = {pix_s1.dst_byte3, pix_s1.dst_byte2, pix_s1.dst_byte1, pix_s1.dst_byte0};

	// One shared multiplier scales either the fill alpha or the stencil alpha.
	assign mul_a    = (pix_s1.req_type == REQ_STENCIL) ? pix_s1.src_alpha : cfg.fill_alpha;
	assign mul_ap1  = {1'b0, mul_a} + 9'd1;
	assign mul_prod = mul_ap1 * {9'd0, pix_s1.coverage};
	assign scaled_a = mul_prod[15:8];

	always_comb begin
		nxt.op       = OP_KEEP;
		nxt.alpha    = scaled_a;
		nxt.dst      = dst;
		nxt.b3       = BYTE_FULL;
		nxt.b3_fixed = 1'b1;
		nxt.col      = layout_order(cfg.pixel_format, cfg.fill_red, cfg.fill_green,
			cfg.fill_blue);
		case (pix_s1.req_type)
			REQ_FILL, REQ_FILL_SCALED: begin
				if (pix_s1.req_type == REQ_FILL && pix_s1.coverage == BYTE_FULL) begin
					nxt.op = OP_STORE;
					nxt.b3 = has_alpha ? cfg.fill_alpha : BYTE_FULL;
				end else begin
					if (pix_s1.req_type == REQ_FILL) begin
						nxt.alpha = pix_s1.coverage;
					end
					if (has_alpha) begin
						nxt.op = OP_LERP;
					end else begin
						nxt.op = OP_PREMUL;
						nxt.b3 = (cfg.pixel_format == FMT_BGRX) ? BYTE_FULL : dst[3];
					end
				end
			end
			REQ_STENCIL: begin
				nxt.col = layout_order(cfg.pixel_format, pix_s1.src_red, pix_s1.src_green,
					pix_s1.src_blue);
				if (pix_s1.src_alpha == 8'd0) begin
					nxt.op = OP_KEEP;
				end else if (pix_s1.coverage != BYTE_FULL || pix_s1.src_alpha != BYTE_FULL) begin
					nxt.op = OP_LERP;
				end else begin
					nxt.op = OP_STORE;
				end
			end
			REQ_ERASE: begin
				nxt.op = (pix_s1.coverage == BYTE_FULL) ? OP_ZERO : OP_KEEP;
			end
			default: nxt.op = OP_KEEP;
		endcase

		// Alpha layouts: an empty destination takes the color as is, and an
		// opaque RGBA destination keeps full alpha; otherwise alpha is blended.
		if (nxt.op == OP_LERP && has_alpha) begin
			if (dst[3] == 8'd0) begin
				nxt.op = OP_STORE;
				nxt.b3 = nxt.alpha;
			end else begin
				nxt.b3_fixed = (cfg.pixel_format == FMT_RGBA) && (dst[3] == BYTE_FULL);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				valid_s1 <= in_valid;
			end
			if (rdy_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			pix_s1 <= in_data;
		end
		if (rdy_s2 && valid_s1) begin
			pix_s2 <= nxt;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/spab_blend.sv =====
// Back half of the blend pipeline: channel products (s3) and the final
// combine into the output register (s4). Depends on spab_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spab_blend (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s2_valid,
	output logic                    s2_stall,
	input  wire spab_pkg::spab_s2_t s2_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output spab_pkg::spab_out_t     out_data
);
	import spab_pkg::*;

	logic       valid_s3;
	spab_s3_t   pix_s3;
	logic       valid_s4;
	spab_out_t  res_s4;
	logic       rdy_s3;
	logic       rdy_s4;

	logic [8:0]       ap1;
	logic [8:0]       inva;
	logic [16:0]      aa_prod;
	logic [16:0]      ad3_prod;
	logic [2:0][16:0] pms_prod;
	logic [2:0][16:0] pmd_prod;
	logic [2:0][18:0] lerp_prod;
	spab_s3_t         nxt3;
	logic [2:0][7:0]  chan;
	logic [7:0]       byte3;
	logic             wen;

	assign rdy_s4    = !valid_s4 || !out_stall;
	assign rdy_s3    = !valid_s3 || rdy_s4;
	assign s2_stall  = !rdy_s3;
	assign out_valid = valid_s4;
	assign out_data  = res_s4;

	assign ap1  = {1'b0, s2_data.alpha} + 9'd1;
	assign inva = 9'd256 - {1'b0, s2_data.alpha};

	assign aa_prod  = ap1 * {9'd0, s2_data.alpha};
	assign ad3_prod = inva * {9'd0, s2_data.dst[3]};

	// The lerp product is signed; taking bits above the fraction is a floor.
	for (genvar i = 0; i < 3; i++) begin : g_chan
		logic signed [9:0] diff;
		assign diff        = $signed({2'b00, s2_data.col[i]}) - $signed({2'b00, s2_data.dst[i]});
		assign lerp_prod[i] = {10'd0, ap1} * {{9{diff[9]}}, diff};
		assign pms_prod[i]  = ap1 * {9'd0, s2_data.col[i]};
		assign pmd_prod[i]  = inva * {9'd0, s2_data.dst[i]};
	end

	always_comb begin
		nxt3.op       = s2_data.op;
		nxt3.col      = s2_data.col;
		nxt3.dst      = s2_data.dst;
		nxt3.b3       = s2_data.b3;
		nxt3.b3_fixed = s2_data.b3_fixed;
		nxt3.aa       = aa_prod[15:8];
		nxt3.ad3      = ad3_prod[15:8];
		for (int i = 0; i < 3; i++) begin
			nxt3.lerp_q[i] = lerp_prod[i][15:8];
			nxt3.pm_src[i] = pms_prod[i][15:8];
			nxt3.pm_dst[i] = pmd_prod[i][15:8];
		end
	end

	always_comb begin
		chan  = pix_s3.dst[2:0];
		byte3 = pix_s3.b3_fixed ? pix_s3.b3 : (pix_s3.aa + pix_s3.ad3);
		wen   = 1'b1;
		case (pix_s3.op)
			OP_KEEP: begin
				chan  = pix_s3.dst[2:0];
				byte3 = pix_s3.dst[3];
				wen   = 1'b0;
			end
			OP_ZERO: begin
				chan  = '0;
				byte3 = 8'd0;
			end
			OP_STORE: chan = pix_s3.col;
			OP_LERP: begin
				for (int i = 0; i < 3; i++) begin
					chan[i] = pix_s3.lerp_q[i] + pix_s3.dst[i];
				end
			end
			OP_PREMUL: begin
				for (int i = 0; i < 3; i++) begin
					chan[i] = pix_s3.pm_src[i] + pix_s3.pm_dst[i];
				end
			end
			default: begin
				chan  = pix_s3.dst[2:0];
				byte3 = pix_s3.dst[3];
				wen   = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy_s3) begin
				valid_s3 <= s2_valid;
			end
			if (rdy_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && s2_valid) begin
			pix_s3 <= nxt3;
		end
		if (rdy_s4 && valid_s3) begin
			res_s4.out_byte0    <= chan[0];
			res_s4.out_byte1    <= chan[1];
			res_s4.out_byte2    <= chan[2];
			res_s4.out_byte3    <= byte3;
			res_s4.write_enable <= wen;
		end
	end

endmodule

`default_nettype wire
